[src/aes128_block_index_whitening_top_defines.svh]
// Assertion macros shared by the checker of the whitening AES top level.
// No dependencies.
`ifndef AES128_BLOCK_INDEX_WHITENING_TOP_DEFINES_SVH
`define AES128_BLOCK_INDEX_WHITENING_TOP_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define AWB_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked on every rising edge outside reset.
`define AWB_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[src/awb_pkg.sv]
// Package for the whitening AES-128 engine: S-box functions and GF helpers.
// No dependencies.
package awb_pkg;
	localparam int KeyWords = 22;

	localparam logic [7:0] SBOX_TBL [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	function automatic logic [7:0] sbox(input logic [7:0] a);
		return SBOX_TBL[a];
	endfunction

	// Inverse S-box, found by searching the forward table.
	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (SBOX_TBL[i] == a) r = 8'(i);
		end
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] u, v;
		logic [31:0] d;
		a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
		// Pre-step with 4x/5x terms, then forward mix.
		u = xt(xt(a[0] ^ a[2]));
		v = xt(xt(a[1] ^ a[3]));
		d = {a[0] ^ u, a[1] ^ v, a[2] ^ u, a[3] ^ v};
		return mix_col(d);
	endfunction
endpackage

[src/aes128_block_index_whitening_top.sv]
// A key write expands the round keys from the new key; the engine is not ready meanwhile.
// Per block: the input transfer loads the state, the rounds run in S_ROUND, then S_OUT
// writes the result into the output register and marks it valid.
// A new block is taken only in S_IDLE with the output register empty; the single shared
// round unit and the wait for the output register to empty limit the block rate.
// Reset: async active low; control, key, state and output registers clear, round keys expand from the zero key.
// Depends on awb_pkg.
module aes128_block_index_whitening_top import awb_pkg::*; #(
	parameter int MAX_BLOCKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [135:0]  s_tdata,  // block_high, block_low, valid_bytes, pad
	input  logic          s_tlast,  // last_block
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,  // result_high, result_low
	output logic          m_tlast,  // result_last
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	localparam int CW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [2:0] RegKeyHi = 3'd0, RegKeyLo = 3'd1, RegIvHi = 3'd2,
		RegIvLo = 3'd3, RegDir = 3'd4;

	typedef enum logic [1:0] {S_EXPAND, S_IDLE, S_ROUND, S_OUT} state_t;

	state_t state_q;
	logic [63:0] key_hi_q, key_lo_q, iv_lo_q;
	logic [55:0] iv_hi_q;
	logic dir_q;
	logic [127:0] rk_mem [11];
	logic [127:0] rk_work_q;
	logic [3:0] rnd_q;
	logic [127:0] st_q;
	logic [127:0] wh_q;
	logic last_q;
	logic [CW-1:0] cnt_q;
	logic [127:0] out_q;
	logic out_last_q, out_v_q;
	logic [127:0] rk_rd_q;

	logic [127:0] blk, wvec, kbytes, st_next, rk_next, wmask, rnd_in;
	logic [4:0] nv;
	logic [7:0] rcon;

	// Byte 0 of the block is the top byte of block_high, which sits in the low word.
	assign blk = {s_tdata[63:0], s_tdata[127:64]};
	assign nv = s_tdata[132:128];

	always_comb begin
		logic [119:0] ivb;
		kbytes = {key_hi_q, key_lo_q};
		ivb = {iv_hi_q, iv_lo_q};
		for (int t = 0; t < 15; t++) begin
			if (dir_q) wvec[127-8*t -: 8] = ivb[119-8*t -: 8];
			else wvec[127-8*t -: 8] = kbytes[127-8*(15-t) -: 8];
		end
		wvec[7:0] = 8'(cnt_q);
		for (int t = 0; t < 16; t++)
			wmask[127-8*t -: 8] = (5'(t) < nv) ? 8'hff : 8'h00;
	end

	// Key schedule step: one round key per cycle from the previous one.
	always_comb begin
		logic [31:0] w0, w1, w2, w3, tw;
		unique case (rnd_q)
			4'd0: rcon = 8'h01; 4'd1: rcon = 8'h02; 4'd2: rcon = 8'h04;
			4'd3: rcon = 8'h08; 4'd4: rcon = 8'h10; 4'd5: rcon = 8'h20;
			4'd6: rcon = 8'h40; 4'd7: rcon = 8'h80; 4'd8: rcon = 8'h1b;
			default: rcon = 8'h36;
		endcase
		w3 = rk_work_q[31:0];
		tw = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = rk_work_q[127:96] ^ tw;
		w1 = rk_work_q[95:64] ^ w0;
		w2 = rk_work_q[63:32] ^ w1;
		rk_next = {w0, w1, w2, rk_work_q[31:0] ^ w2};
	end

	// Shared round unit; direction picks forward or inverse round.
	always_comb begin
		logic [7:0] sb [16];
		logic [7:0] sr [16];
		logic [127:0] m;
		rnd_in = st_q;
		for (int i = 0; i < 16; i++) sb[i] = 8'h00;
		if (!dir_q) begin
			for (int i = 0; i < 16; i++) sb[i] = sbox(rnd_in[127-8*i -: 8]);
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++) sr[r+4*c] = sb[r+4*((c+r)&3)];
			for (int c = 0; c < 4; c++)
				m[127-32*c -: 32] = (rnd_q != 4'd10) ?
					mix_col({sr[4*c], sr[4*c+1], sr[4*c+2], sr[4*c+3]}) :
					{sr[4*c], sr[4*c+1], sr[4*c+2], sr[4*c+3]};
			st_next = m ^ rk_rd_q;
		end else begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++) sr[r+4*((c+r)&3)] = rnd_in[127-8*(r+4*c) -: 8];
			for (int i = 0; i < 16; i++) sb[i] = inv_sbox(sr[i]);
			for (int c = 0; c < 4; c++) m[127-32*c -: 32] =
				{sb[4*c], sb[4*c+1], sb[4*c+2], sb[4*c+3]} ^ rk_rd_q[127-32*c -: 32];
			for (int c = 0; c < 4; c++)
				st_next[127-32*c -: 32] = (rnd_q != 4'd10) ?
					inv_mix_col(m[127-32*c -: 32]) : m[127-32*c -: 32];
		end
	end

	// Round key memory: written during expansion, read one key a cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_EXPAND) rk_mem[rnd_q] <= rk_work_q;
		if (state_q == S_ROUND && rnd_q != 4'd10) begin
			rk_rd_q <= rk_mem[dir_q ? 4'(9 - rnd_q) : 4'(rnd_q + 4'd1)];
		end else if (state_q == S_IDLE) begin
			rk_rd_q <= rk_mem[dir_q ? 4'd9 : 4'd1];
		end
	end

	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q[63:0], out_q[127:64]};
	assign m_tlast = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EXPAND;
			key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0; dir_q <= 1'b0;
			rk_work_q <= '0; rnd_q <= '0; cnt_q <= '0; out_v_q <= 1'b0;
			st_q <= '0; wh_q <= '0; last_q <= 1'b0; out_q <= '0; out_last_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					RegKeyHi: begin
						key_hi_q <= cfg_data;
						rk_work_q <= {cfg_data, key_lo_q};
						rnd_q <= '0; state_q <= S_EXPAND;
					end
					RegKeyLo: begin
						key_lo_q <= cfg_data;
						rk_work_q <= {key_hi_q, cfg_data};
						rnd_q <= '0; state_q <= S_EXPAND;
					end
					RegIvHi: iv_hi_q <= cfg_data[55:0];
					RegIvLo: iv_lo_q <= cfg_data;
					RegDir: dir_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (!(cfg_we && (cfg_index == RegKeyHi || cfg_index == RegKeyLo))) begin
				unique case (state_q)
					S_EXPAND: begin
						rk_work_q <= rk_next;
						if (rnd_q == 4'd10) begin
							rnd_q <= '0; state_q <= S_IDLE;
						end else rnd_q <= rnd_q + 4'd1;
					end
					S_IDLE: if (s_tvalid && s_tready) begin
						// Input whitening when encrypting, and the first key add.
						if (!dir_q) st_q <= (blk ^ (wvec & wmask)) ^ rk_mem[0];
						else st_q <= blk ^ rk_mem[10];
						wh_q <= wvec;
						last_q <= s_tlast;
						rnd_q <= 4'd1;
						state_q <= S_ROUND;
						if (s_tlast || cnt_q == CW'(MAX_BLOCKS - 1)) cnt_q <= '0;
						else cnt_q <= cnt_q + 1'b1;
					end
					S_ROUND: begin
						st_q <= st_next;
						if (rnd_q == 4'd10) state_q <= S_OUT;
						rnd_q <= rnd_q + 4'd1;
					end
					S_OUT: begin
						out_q <= dir_q ? (st_q ^ wh_q) : st_q;
						out_last_q <= last_q;
						out_v_q <= 1'b1;
						rnd_q <= '0;
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

[src/awb_checker.sv]
// Port-level checker for the whitening AES top level, bound to it below.
// Depends on aes128_block_index_whitening_top_defines.svh.
`include "aes128_block_index_whitening_top_defines.svh"
module awb_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic [127:0] m_tdata
);
	// A transfer in means no result can appear on the next cycle.
	`AWB_ASSERT_NEXT(a_no_fast_out, s_tvalid && s_tready, !m_tvalid)
	// The engine never accepts a block while a result waits.
	`AWB_ASSERT_IMP(a_busy_out, m_tvalid, !s_tready)
	// A stalled result holds.
	`AWB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
endmodule

bind aes128_block_index_whitening_top awb_checker u_awb_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata));

[tb/sv/aes128_block_index_whitening_top_tb.sv]
// Self-checking testbench for the whitening AES-128 top level: directed blocks, then random
// messages under several key, iv and direction settings, with bursty input and output stalls.
// Depends on the RTL top level; the expected results come from a local AES model.
module aes128_block_index_whitening_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLOCKS = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 215;

	typedef enum logic [2:0] {
		REG_KEY_HIGH  = 3'd0,
		REG_KEY_LOW   = 3'd1,
		REG_IV_HIGH   = 3'd2,
		REG_IV_LOW    = 3'd3,
		REG_DIRECTION = 3'd4,
		REG_SPARE5    = 3'd5,
		REG_SPARE6    = 3'd6,
		REG_SPARE7    = 3'd7
	} reg_index_e;

	localparam bit DIR_ENCRYPT = 1'b0;
	localparam bit DIR_DECRYPT = 1'b1;

	localparam bit [7:0] SUB_BYTE [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	typedef bit [7:0] aes_bytes_t [16];

	typedef struct packed {
		bit [63:0] hi;
		bit [63:0] lo;
		bit        last;
	} cipher_block_t;

	class aes_whiten_checker;
		bit [63:0] key_hi, key_lo, iv_hi, iv_lo;
		bit        dir;
		bit [63:0] round_keys [22];
		bit [3:0]  blk_index;
		bit [7:0]  inv_sub [256];
		cipher_block_t expected_q [$];
		int        mismatches;

		function new();
			for (int i = 0; i < 256; i++) inv_sub[SUB_BYTE[i]] = 8'(i);
			key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
			dir = DIR_ENCRYPT;
			blk_index = '0;
			mismatches = 0;
			expand_keys();
		endfunction

		function aes_bytes_t to_bytes(bit [63:0] hi, bit [63:0] lo);
			aes_bytes_t b;
			for (int i = 0; i < 8; i++) begin
				b[i] = hi[63 - 8 * i -: 8];
				b[8 + i] = lo[63 - 8 * i -: 8];
			end
			return b;
		endfunction

		function bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
			bit [7:0] r;
			r = '0;
			for (int i = 0; i < 8; i++) begin
				if (b[i]) r ^= a;
				a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			end
			return r;
		endfunction

		function void mix_columns(inout aes_bytes_t s, input bit [7:0] m [4]);
			bit [7:0] a [4];
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) a[r] = s[4 * c + r];
				for (int r = 0; r < 4; r++)
					s[4 * c + r] = gf_mul(a[0], m[(4 - r) & 3]) ^ gf_mul(a[1], m[(5 - r) & 3])
						^ gf_mul(a[2], m[(6 - r) & 3]) ^ gf_mul(a[3], m[(7 - r) & 3]);
			end
		endfunction

		function void expand_keys();
			bit [7:0] w [176];
			bit [7:0] t [4];
			bit [7:0] f;
			aes_bytes_t k;
			bit [7:0] rc;
			k = to_bytes(key_hi, key_lo);
			for (int i = 0; i < 16; i++) w[i] = k[i];
			rc = 8'h01;
			for (int i = 16; i < 176; i += 4) begin
				for (int j = 0; j < 4; j++) t[j] = w[i - 4 + j];
				if (i % 16 == 0) begin
					f = t[0];
					t[0] = SUB_BYTE[t[1]] ^ rc;
					t[1] = SUB_BYTE[t[2]];
					t[2] = SUB_BYTE[t[3]];
					t[3] = SUB_BYTE[f];
					rc = gf_mul(rc, 8'h02);
				end
				for (int j = 0; j < 4; j++) w[i + j] = w[i - 16 + j] ^ t[j];
			end
			for (int i = 0; i < 22; i++)
				for (int j = 0; j < 8; j++) round_keys[i][63 - 8 * j -: 8] = w[8 * i + j];
		endfunction

		function void add_round_key(inout aes_bytes_t s, input int rnd);
			aes_bytes_t k;
			k = to_bytes(round_keys[2 * rnd], round_keys[2 * rnd + 1]);
			for (int i = 0; i < 16; i++) s[i] ^= k[i];
		endfunction

		function void encrypt(inout aes_bytes_t s);
			bit [7:0] m [4];
			aes_bytes_t t;
			m = '{8'd2, 8'd3, 8'd1, 8'd1};
			add_round_key(s, 0);
			for (int rnd = 1; rnd <= 10; rnd++) begin
				for (int i = 0; i < 16; i++) s[i] = SUB_BYTE[s[i]];
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++) t[r + 4 * c] = s[r + 4 * ((c + r) & 3)];
				s = t;
				if (rnd < 10) mix_columns(s, m);
				add_round_key(s, rnd);
			end
		endfunction

		function void decrypt(inout aes_bytes_t s);
			bit [7:0] m [4];
			aes_bytes_t t;
			m = '{8'd14, 8'd11, 8'd13, 8'd9};
			add_round_key(s, 10);
			for (int rnd = 9; rnd >= 0; rnd--) begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++) t[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
				for (int i = 0; i < 16; i++) s[i] = inv_sub[t[i]];
				add_round_key(s, rnd);
				if (rnd > 0) mix_columns(s, m);
			end
		endfunction

		function void write_reg(reg_index_e idx, bit [63:0] value);
			case (idx)
				REG_KEY_HIGH: begin key_hi = value; expand_keys(); end
				REG_KEY_LOW: begin key_lo = value; expand_keys(); end
				REG_IV_HIGH: iv_hi = {8'h00, value[55:0]};
				REG_IV_LOW: iv_lo = value;
				REG_DIRECTION: dir = value[0];
				default: ;
			endcase
		endfunction

		function void note_block(bit [63:0] hi, bit [63:0] lo, bit [4:0] nvalid, bit last);
			aes_bytes_t s, w, k;
			cipher_block_t res;
			int n;
			s = to_bytes(hi, lo);
			if (dir == DIR_ENCRYPT) begin
				k = to_bytes(key_hi, key_lo);
				for (int i = 0; i < 15; i++) w[i] = k[15 - i];
			end else begin
				w = to_bytes({iv_hi[55:0], iv_lo[63:56]}, {iv_lo[55:0], 8'h00});
			end
			w[15] = 8'(blk_index);
			if (dir == DIR_ENCRYPT) begin
				// Counts above sixteen whiten the whole block.
				n = (nvalid > 16) ? 16 : nvalid;
				for (int i = 0; i < n; i++) s[i] ^= w[i];
				encrypt(s);
			end else begin
				decrypt(s);
				for (int i = 0; i < 16; i++) s[i] ^= w[i];
			end
			for (int i = 0; i < 8; i++) begin
				res.hi[63 - 8 * i -: 8] = s[i];
				res.lo[63 - 8 * i -: 8] = s[8 + i];
			end
			res.last = last;
			expected_q.push_back(res);
			blk_index = last ? 4'd0 : 4'((blk_index + 1) % MAX_BLOCKS);
		endfunction

		function void check_result(bit [63:0] hi, bit [63:0] lo, bit last);
			cipher_block_t exp_res;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %h %h last=%b", hi, lo, last);
				return;
			end
			exp_res = expected_q.pop_front();
			if (exp_res.hi !== hi || exp_res.lo !== lo || exp_res.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h %h last=%b, got %h %h last=%b",
						exp_res.hi, exp_res.lo, exp_res.last, hi, lo, last);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [135:0]  s_tdata = '0;
	logic          s_tlast = 1'b0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [127:0]  m_tdata;
	logic          m_tlast;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = '0;
	logic [63:0]   cfg_data = '0;

	aes_whiten_checker chk = new();
	int  cycle_count = 0;
	int  burst_left = 0;
	bit  offering = 0;
	bit  hold_req = 0;
	int  hold_left = 0;

	aes128_block_index_whitening_top #(.MAX_BLOCKS(MAX_BLOCKS)) uut (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) chk.check_result(m_tdata[63:0], m_tdata[127:64], m_tlast);

	// Output stall pattern steps through four modes with the cycle count; a requested hold-off overrides it.
	initial forever begin
		@(posedge clk);
		if (hold_req) begin
			hold_left = 600;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case ((cycle_count / 256) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((cycle_count % 7) < 4);
			endcase
		end
	end

	task automatic send_block(bit [63:0] hi, bit [63:0] lo, bit [4:0] nvalid, bit last);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, nvalid, lo, hi};
		s_tlast <= last;
		offering = 1;
		do @(posedge clk); while (!s_tready);
		chk.note_block(hi, lo, nvalid, last);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			offering = 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end else begin
			burst_left--;
		end
	endtask

	// Stop offering and let every outstanding result drain before touching registers.
	task automatic quiesce();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 0;
		end
		do @(posedge clk); while (chk.outstanding() > 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic cfg_write(reg_index_e idx, bit [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		chk.write_reg(idx, value);
	endtask

	task automatic configure(bit [63:0] kh, bit [63:0] kl, bit [63:0] ih, bit [63:0] il,
			bit dir);
		cfg_write(REG_KEY_HIGH, kh);
		cfg_write(REG_KEY_LOW, kl);
		cfg_write(REG_IV_HIGH, ih);
		cfg_write(REG_IV_LOW, il);
		cfg_write(REG_DIRECTION, {63'd0, dir});
		cfg_we <= 1'b0;
	endtask

	function automatic bit [4:0] pick_valid_bytes();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return 5'($urandom_range(1, 16));
		if (r == 7) return 5'd0;
		return 5'($urandom_range(17, 31));
	endfunction

	initial begin
		bit [63:0] ones;
		bit [63:0] kh, kl, ih, il;
		int sent, len;
		ones = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: encrypt with the all-zero key; no, partial, full and oversized masks.
		send_block(64'd0, 64'd0, 5'd0, 1'b0);
		send_block(ones, ones, 5'd16, 1'b0);
		send_block(ones, 64'd0, 5'd31, 1'b0);
		send_block(64'd0, ones, 5'd17, 1'b1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1, 1'b1);
		quiesce();

		configure(ones, ones, ones, ones, DIR_ENCRYPT);
		send_block(64'd0, 64'd0, 5'd8, 1'b0);
		send_block(ones, ones, 5'd15, 1'b0);
		send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff, 5'd16, 1'b0);
		send_block(ones, 64'd0, 5'd0, 1'b1);
		quiesce();

		configure(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h00a1b2c3d4e5f607,
			64'h1122334455667788, DIR_DECRYPT);
		send_block(64'd0, 64'd0, 5'd0, 1'b0);
		send_block(ones, ones, 5'd31, 1'b0);
		send_block(64'h3925841d02dc09fb, 64'hdc118597196a0b32, 5'd16, 1'b1);
		quiesce();

		// Writes to unused indexes must leave every register alone.
		cfg_write(REG_SPARE5, ones);
		cfg_write(REG_SPARE6, ones);
		cfg_write(REG_SPARE7, ones);
		cfg_we <= 1'b0;
		send_block(ones, 64'h5555aaaa5555aaaa, 5'd4, 1'b0);
		send_block(64'haaaa5555aaaa5555, ones, 5'd12, 1'b1);
		quiesce();

		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 3))
				0: begin kh = '0; kl = '0; ih = '0; il = '0; end
				1: begin kh = ones; kl = ones; ih = ones; il = ones; end
				default: begin
					kh = {$urandom, $urandom}; kl = {$urandom, $urandom};
					ih = {$urandom, $urandom}; il = {$urandom, $urandom};
				end
			endcase
			configure(kh, kl, ih, il, phase[0] ? DIR_DECRYPT : DIR_ENCRYPT);
			if (phase == 1 || phase == 4) hold_req = 1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// Messages up to twenty blocks long so the index also wraps at its bound.
				len = $urandom_range(1, 20);
				for (int j = 0; j < len && sent < PHASE_ITEMS; j++) begin
					send_block({$urandom, $urandom}, {$urandom, $urandom}, pick_valid_bytes(),
						($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1))
							: (j == len - 1));
					sent++;
				end
			end
			quiesce();
		end

		if (chk.mismatches == 0 && chk.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
